[hw/rtl/rational_arith_unit_core_assert.svh]
// Assertion macros for the rational arithmetic unit checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
// Shared types, codes and constants for the rational arithmetic unit.
// No dependencies.
`default_nettype none

package rau_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W         = 32;
  localparam int unsigned FUNC_W          = 3;
  localparam int unsigned IN_DATA_W       = 136;
  localparam int unsigned OUT_DATA_W      = 72;

  // input tdata field offsets
  localparam int unsigned IN_A_NUM   = 0;
  localparam int unsigned IN_A_DEN   = 32;
  localparam int unsigned IN_A_VALID = 64;
  localparam int unsigned IN_B_NUM   = 65;
  localparam int unsigned IN_B_DEN   = 97;
  localparam int unsigned IN_B_VALID = 129;

  localparam int unsigned OUT_USED_W = 66;

  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CMP  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_NORM = 3'd5;

  // multiplier operand pairs
  localparam logic [3:0] MS_NA_QB = 4'd0;
  localparam logic [3:0] MS_NB_QA = 4'd1;
  localparam logic [3:0] MS_QA_DB = 4'd2;
  localparam logic [3:0] MS_DA_DB = 4'd3;
  localparam logic [3:0] MS_NA_NB = 4'd4;
  localparam logic [3:0] MS_DA_NB = 4'd5;
  localparam logic [3:0] MS_NA_DB = 4'd6;
  localparam logic [3:0] MS_CMP_L = 4'd7;
  localparam logic [3:0] MS_CMP_R = 4'd8;

  // destinations for the product register
  localparam logic [2:0] WD_NONE = 3'd0;
  localparam logic [2:0] WD_TA   = 3'd1;
  localparam logic [2:0] WD_N    = 3'd2;
  localparam logic [2:0] WD_D    = 3'd3;
  localparam logic [2:0] WD_NADD = 3'd4;
  localparam logic [2:0] WD_NSUB = 3'd5;
  localparam logic [2:0] WD_PL   = 3'd6;
  localparam logic [2:0] WD_ND_A = 3'd7;

  localparam logic [1:0] DS_DA = 2'd0;
  localparam logic [1:0] DS_DB = 2'd1;
  localparam logic [1:0] DS_N  = 2'd2;
  localparam logic [1:0] DS_D  = 2'd3;

  localparam logic [1:0] DD_QA = 2'd0;
  localparam logic [1:0] DD_QB = 2'd1;
  localparam logic [1:0] DD_MN = 2'd2;
  localparam logic [1:0] DD_MD = 2'd3;

  localparam logic GS_DEN = 1'b0;
  localparam logic GS_RES = 1'b1;

  localparam logic [1:0] KD_INV  = 2'd0;
  localparam logic [1:0] KD_FRAC = 2'd1;
  localparam logic [1:0] KD_CMP  = 2'd2;

  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;
  localparam logic [1:0] ORD_LT = 2'b11;

  typedef struct packed {
    logic       load;
    logic       gcd_start;
    logic       gcd_src;
    logic       div_start;
    logic [1:0] div_src;
    logic       div_cap;
    logic [1:0] div_dst;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic [2:0] wr_dst;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic nb_nz;
    logic d_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/rau_gcd.sv]
// Binary (Stein) gcd unit, one shift or subtract per cycle.
// Standalone; used by the datapath.
`default_nettype none

module rau_gcd #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      g
);
  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]  a_r, b_r, g_r;
  logic [KW-1:0] k_r;
  logic          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (a_r == '0) begin
          g_r    <= b_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (b_r == '0) begin
          g_r    <= a_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r >= b_r) begin
          a_r <= a_r - b_r;
        end else begin
          b_r <= b_r - a_r;
        end
      end
    end
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

`default_nettype wire

[hw/rtl/rau_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the datapath.
`default_nettype none

module rau_div #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    sh, diff;

  assign sh   = {rem_r, quo_r[W-1]};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= CW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= sh[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

[hw/rtl/rau_dp.sv]
// Datapath: operand registers, shared multiplier, gcd and divider units, result register.
// Depends on rau_pkg, rau_gcd and rau_div.
`default_nettype none

module rau_dp #(
  parameter int unsigned W = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [rau_pkg::IN_DATA_W-1:0]   in_data,
  input  wire rau_pkg::cmd_t                   cmd,
  output rau_pkg::sts_t                        sts,
  output logic [rau_pkg::OUT_DATA_W-1:0]       out_data
);
  import rau_pkg::*;

  function automatic logic [W-1:0] f_abs(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  logic [W-1:0]   na_r, da_r, nb_r, db_r;
  logic           av_r, bv_r;
  logic [W-1:0]   qa_r, qb_r, ta_r, n_r, d_r, mn_r, md_r;
  logic [2*W-1:0] p_r, pl_r;

  logic [W-1:0]   gcd_a, gcd_b, g_w, dvd, q_w, opa, opb, rn;
  logic           gcd_done, div_done;
  logic           sa, sb, neg;
  logic [1:0]     order_w;

  logic [FIELD_W-1:0]   rnum_r;
  logic [FIELD_W-2:0]   rden_r;
  logic                 rval_r;
  logic [1:0]           rord_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      na_r <= in_data[IN_A_NUM +: W];
      da_r <= in_data[IN_A_DEN +: W];
      av_r <= in_data[IN_A_VALID];
      nb_r <= in_data[IN_B_NUM +: W];
      db_r <= in_data[IN_B_DEN +: W];
      bv_r <= in_data[IN_B_VALID];
    end
  end

  assign gcd_a = (cmd.gcd_src == GS_RES) ? f_abs(n_r) : f_abs(da_r);
  assign gcd_b = (cmd.gcd_src == GS_RES) ? f_abs(d_r) : f_abs(db_r);

  rau_gcd #(.W(W)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.gcd_start),
    .a     (gcd_a),
    .b     (gcd_b),
    .done  (gcd_done),
    .g     (g_w)
  );

  always_comb begin
    case (cmd.div_src)
      DS_DA:   dvd = f_abs(da_r);
      DS_DB:   dvd = f_abs(db_r);
      DS_N:    dvd = f_abs(n_r);
      default: dvd = f_abs(d_r);
    endcase
  end

  rau_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (g_w),
    .done     (div_done),
    .quot     (q_w)
  );

  // quotients of the denominators take the sign back
  always_ff @(posedge clk) begin
    if (div_done && cmd.div_cap) begin
      case (cmd.div_dst)
        DD_QA:   qa_r <= da_r[W-1] ? (~q_w + 1'b1) : q_w;
        DD_QB:   qb_r <= db_r[W-1] ? (~q_w + 1'b1) : q_w;
        DD_MN:   mn_r <= q_w;
        default: md_r <= q_w;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_NA_QB: begin opa = na_r;        opb = qb_r;        end
      MS_NB_QA: begin opa = nb_r;        opb = qa_r;        end
      MS_QA_DB: begin opa = qa_r;        opb = db_r;        end
      MS_DA_DB: begin opa = da_r;        opb = db_r;        end
      MS_NA_NB: begin opa = na_r;        opb = nb_r;        end
      MS_DA_NB: begin opa = da_r;        opb = nb_r;        end
      MS_NA_DB: begin opa = na_r;        opb = db_r;        end
      MS_CMP_L: begin opa = f_abs(na_r); opb = f_abs(db_r); end
      default:  begin opa = f_abs(nb_r); opb = f_abs(da_r); end
    endcase
  end

  // low W bits of the unsigned product equal the wrapped signed product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r <= opa * opb;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.wr_dst)
      WD_TA:   ta_r <= p_r[W-1:0];
      WD_N:    n_r  <= p_r[W-1:0];
      WD_D:    d_r  <= p_r[W-1:0];
      WD_NADD: n_r  <= ta_r + p_r[W-1:0];
      WD_NSUB: n_r  <= ta_r - p_r[W-1:0];
      WD_PL:   pl_r <= p_r;
      WD_ND_A: begin
        n_r <= na_r;
        d_r <= da_r;
      end
      default: ;
    endcase
  end

  // exact compare of sign * magnitude products
  assign sa = (na_r[W-1] ^ da_r[W-1]) & (|na_r);
  assign sb = (nb_r[W-1] ^ db_r[W-1]) & (|nb_r);

  always_comb begin
    if (sa != sb) begin
      order_w = sa ? ORD_LT : ORD_GT;
    end else if (pl_r == p_r) begin
      order_w = ORD_EQ;
    end else if (sa ? (pl_r < p_r) : (pl_r > p_r)) begin
      order_w = ORD_GT;
    end else begin
      order_w = ORD_LT;
    end
  end

  assign neg = n_r[W-1] ^ d_r[W-1];
  assign rn  = neg ? (~mn_r + 1'b1) : mn_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rnum_r <= '0;
      rden_r <= (FIELD_W-1)'(1);
      rval_r <= 1'b0;
      rord_r <= ORD_EQ;
      case (cmd.out_kind)
        KD_FRAC: begin
          // a denominator of 2^(W-1) cannot be made positive
          if (!md_r[W-1]) begin
            rnum_r <= FIELD_W'(signed'(rn));
            rden_r <= (FIELD_W-1)'(md_r);
            rval_r <= 1'b1;
          end
        end
        KD_CMP:  rord_r <= order_w;
        default: ;
      endcase
    end
  end

  assign out_data = {(OUT_DATA_W-OUT_USED_W)'(0), rord_r, rval_r, rden_r, rnum_r};

  assign sts.a_ok     = av_r & (|da_r);
  assign sts.b_ok     = bv_r & (|db_r);
  assign sts.nb_nz    = |nb_r;
  assign sts.d_zero   = ~(|d_r);
  assign sts.gcd_done = gcd_done;
  assign sts.div_done = div_done;

endmodule

`default_nettype wire

[hw/rtl/rau_ctrl.sv]
// Controller: sequences one item through the datapath and owns the handshakes.
// Depends on rau_pkg.
`default_nettype none

module rau_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_fire,
  input  wire logic [rau_pkg::FUNC_W-1:0]  func,
  input  wire logic                        out_ready,
  input  wire rau_pkg::sts_t               sts,
  output logic                             in_ready,
  output logic                             out_valid,
  output rau_pkg::cmd_t                    cmd
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_G1   = 4'd2;
  localparam logic [3:0] S_D1   = 4'd3;
  localparam logic [3:0] S_D2   = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_M3   = 4'd7;
  localparam logic [3:0] S_M4   = 4'd8;
  localparam logic [3:0] S_RED  = 4'd9;
  localparam logic [3:0] S_G2   = 4'd10;
  localparam logic [3:0] S_D3   = 4'd11;
  localparam logic [3:0] S_D4   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              ov_r, ov_nxt;
  logic              is_addsub;

  assign is_addsub = (func_r == FN_ADD) || (func_r == FN_SUB);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          func_nxt  = func;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        kind_nxt  = KD_INV;
        state_nxt = S_OUT;
        unique case (func_r) inside
          FN_ADD, FN_SUB: begin
            if (sts.a_ok && sts.b_ok) begin
              cmd.gcd_start = 1'b1;
              cmd.gcd_src   = GS_DEN;
              state_nxt     = S_G1;
            end
          end
          FN_MUL, FN_CMP: begin
            if (sts.a_ok && sts.b_ok) state_nxt = S_M1;
          end
          FN_DIV: begin
            if (sts.a_ok && sts.b_ok && sts.nb_nz) state_nxt = S_M1;
          end
          FN_NORM: begin
            if (sts.a_ok) begin
              cmd.wr_dst = WD_ND_A;
              state_nxt  = S_RED;
            end
          end
          default: ;
        endcase
      end
      S_G1: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_DA;
          state_nxt     = S_D1;
        end
      end
      S_D1: begin
        cmd.div_cap = 1'b1;
        cmd.div_dst = DD_QA;
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_DB;
          state_nxt     = S_D2;
        end
      end
      S_D2: begin
        cmd.div_cap = 1'b1;
        cmd.div_dst = DD_QB;
        if (sts.div_done) state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul_en = 1'b1;
        if (is_addsub)             cmd.mul_sel = MS_NA_QB;
        else if (func_r == FN_MUL) cmd.mul_sel = MS_DA_DB;
        else if (func_r == FN_DIV) cmd.mul_sel = MS_DA_NB;
        else                       cmd.mul_sel = MS_CMP_L;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul_en = 1'b1;
        if (is_addsub) begin
          cmd.wr_dst  = WD_TA;
          cmd.mul_sel = MS_NB_QA;
        end else if (func_r == FN_MUL) begin
          cmd.wr_dst  = WD_D;
          cmd.mul_sel = MS_NA_NB;
        end else if (func_r == FN_DIV) begin
          cmd.wr_dst  = WD_D;
          cmd.mul_sel = MS_NA_DB;
        end else begin
          cmd.wr_dst  = WD_PL;
          cmd.mul_sel = MS_CMP_R;
        end
        state_nxt = S_M3;
      end
      S_M3: begin
        if (is_addsub) begin
          cmd.wr_dst  = (func_r == FN_ADD) ? WD_NADD : WD_NSUB;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_QA_DB;
          state_nxt   = S_M4;
        end else if (func_r == FN_CMP) begin
          kind_nxt  = KD_CMP;
          state_nxt = S_OUT;
        end else begin
          cmd.wr_dst = WD_N;
          state_nxt  = S_RED;
        end
      end
      S_M4: begin
        cmd.wr_dst = WD_D;
        state_nxt  = S_RED;
      end
      S_RED: begin
        if (sts.d_zero) begin
          kind_nxt  = KD_INV;
          state_nxt = S_OUT;
        end else begin
          cmd.gcd_start = 1'b1;
          cmd.gcd_src   = GS_RES;
          state_nxt     = S_G2;
        end
      end
      S_G2: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_N;
          state_nxt     = S_D3;
        end
      end
      S_D3: begin
        cmd.div_cap = 1'b1;
        cmd.div_dst = DD_MN;
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_D;
          state_nxt     = S_D4;
        end
      end
      S_D4: begin
        cmd.div_cap = 1'b1;
        cmd.div_dst = DD_MD;
        if (sts.div_done) begin
          kind_nxt  = KD_FRAC;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = kind_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r & ~out_ready;
    if (cmd.out_load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      kind_r  <= KD_INV;
      func_r  <= FN_ADD;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      kind_r  <= kind_nxt;
      func_r  <= func_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule

`default_nettype wire

[hw/rtl/rational_arith_unit_core.sv]
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
// channel | dir | tdata                                | tuser
// in_     | in  | a_num a_den a_valid b_num b_den b_valid | func
// out_    | out | res_num res_den res_valid order         | -
//
// One item at a time. Add/subtract: two gcd passes and four divisions;
// multiply and divide: one gcd pass and two divisions; compare: neither.
// Most of the time goes to the gcd unit and the bit-serial divider.
// rst_n is synchronous, active low; no clearing pass.
// A new item is taken while a finished result waits at the output register.
`default_nettype none

module rational_arith_unit_core #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // a_num[31:0] a_den[63:32] a_valid[64] b_num[96:65] b_den[128:97] b_valid[129]
  input  wire logic [rau_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[2:0]
  input  wire logic [rau_pkg::FUNC_W-1:0]       in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // res_num[31:0] res_den[62:32] res_valid[63] order[65:64]
  output logic [rau_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_tvalid & in_tready;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .func      (in_tuser),
    .out_ready (out_tready),
    .sts       (sts),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  rau_dp #(.W(VALUE_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/rau_checker.sv]
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arith_unit_core_assert.svh.
`default_nettype none

`include "rational_arith_unit_core_assert.svh"

module rau_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [rau_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);
  import rau_pkg::*;

  `RAU_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `RAU_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `RAU_ASSERT_IMP(a_invalid_frac, out_tvalid && !out_tdata[63], out_tdata[62:0] == {31'd1, 32'd0}, "invalid result is not 0/1")
  `RAU_ASSERT_IMP(a_order_only_cmp, out_tvalid && out_tdata[63], out_tdata[65:64] == ORD_EQ, "order set on a fraction result")
  `RAU_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[OUT_DATA_W-1:OUT_USED_W] == '0, "padding bits set")

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
